FILE: hdl/mpr_pkg.sv
// Package for the matrix point rotation block: beat types, number formats,
// register map and the elaboration-time sine table builder.
// No dependencies.
package mpr_pkg;

  // Table size (power of two) and trig fraction bits, Q1.(TRIG_FRAC_BITS)
  localparam int ANGLE_STEPS    = 256;
  localparam int TRIG_FRAC_BITS = 14;

  localparam int IDX_W        = $clog2(ANGLE_STEPS);
  localparam int QUARTER_TURN = ANGLE_STEPS / 4;
  localparam int TRIG_W       = TRIG_FRAC_BITS + 2;
  localparam int ANGLE_W      = 8;
  localparam int COORD_W      = 24;
  localparam int PROD_W       = COORD_W + TRIG_W;
  localparam int SUM_W        = PROD_W + 2;
  localparam int RS_W         = SUM_W - TRIG_FRAC_BITS;
  localparam int PADDR_W      = 4;
  localparam int PDATA_W      = 32;

  // register map, index = paddr[3:2]
  localparam logic [1:0] REG_ANGLE_X = 2'd0;
  localparam logic [1:0] REG_ANGLE_Y = 2'd1;
  localparam logic [1:0] REG_ANGLE_Z = 2'd2;

  localparam logic signed [TRIG_W-1:0]   TRIG_ONE  = TRIG_W'(1) << TRIG_FRAC_BITS;
  localparam logic signed [TRIG_W-1:0]   TRIG_MONE = -TRIG_ONE;
  localparam logic signed [2*TRIG_W-1:0] TRIG_HALF = (2*TRIG_W)'(1) << (TRIG_FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0]    SUM_HALF  = SUM_W'(1) << (TRIG_FRAC_BITS - 1);

  localparam logic [63:0] PI_HALF_Q61 = 64'h3243F6A8885A308D;

  typedef struct packed {
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic signed [COORD_W-1:0] in_z;
    logic                      last_point;
  } in_beat_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      out_last;
  } out_beat_t;

  typedef logic signed [TRIG_W-1:0] sine_tab_t [ANGLE_STEPS];

  // (a*b) >> 61, exact
  function automatic logic [63:0] mulq61(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[124:61];
  endfunction

  // unsigned long division, only evaluated while the table is built
  function automatic logic [63:0] div_u64(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // sin(2*pi*i/ANGLE_STEPS) in Q1.F by Taylor series on a Q61 argument
  function automatic logic signed [TRIG_W-1:0] sine_sample(int unsigned i);
    logic [63:0] frac;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] negs;
    logic [63:0] s;
    logic [63:0] v;
    logic [63:0] den;
    logic        neg;
    int          k;
    frac = 64'(i) << (52 - IDX_W);
    neg  = 1'b0;
    if (frac >= (64'd1 << 51)) begin
      frac = frac - (64'd1 << 51);
      neg  = 1'b1;
    end
    if (frac > (64'd1 << 50)) begin
      frac = (64'd1 << 51) - frac;
    end
    x    = mulq61(PI_HALF_Q61, frac << 11);
    x2   = mulq61(x, x);
    term = x;
    pos  = x;
    negs = 64'd0;
    for (k = 1; k <= 12; k++) begin
      den  = 64'((2 * k) * (2 * k + 1));
      term = div_u64(mulq61(term, x2), den);
      if ((k & 1) != 0) negs = negs + term;
      else              pos  = pos + term;
    end
    s = pos - negs;
    v = (s + (64'd1 << (60 - TRIG_FRAC_BITS))) >> (61 - TRIG_FRAC_BITS);
    return neg ? -TRIG_W'(v) : TRIG_W'(v);
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t t;
    for (int unsigned i = 0; i < ANGLE_STEPS; i++) begin
      t[i] = sine_sample(i);
    end
    return t;
  endfunction

  // rounded Q1.F product, round half up
  function automatic logic signed [TRIG_W-1:0] mr(logic signed [TRIG_W-1:0] a,
                                                  logic signed [TRIG_W-1:0] b);
    logic signed [2*TRIG_W-1:0] p;
    p = a * b + TRIG_HALF;
    return p[TRIG_FRAC_BITS +: TRIG_W];
  endfunction

  // clamp a term sum to [-1, 1]
  function automatic logic signed [TRIG_W-1:0] clamp_term(logic signed [TRIG_W:0] v);
    if (v > (TRIG_W+1)'(TRIG_ONE))  return TRIG_ONE;
    if (v < (TRIG_W+1)'(TRIG_MONE)) return TRIG_MONE;
    return v[TRIG_W-1:0];
  endfunction

endpackage

FILE: hdl/matrix_point_rotation.sv
// Matrix point rotation, top level: angle registers, matrix rebuild pipe and
// the three-stage point datapath. Depends on mpr_pkg.
//
// Use:
//  - Input beats (in_valid/in_stall, in_data) carry one Q16.8 point and its
//    last flag; output beats (out_valid/out_stall, out_data) carry the rotated
//    point, rounded and saturated to 24 bits, with the flag copied.
//  - Throughput: one point per cycle unless in_stall is raised by out_stall,
//    an APB write or a matrix rebuild. Each beat passes the multiply,
//    sum/round and saturate registers in turn before it leaves.
//  - Three angle registers (APB, byte addresses 0, 4, 8; bits 7:0) select
//    sine table entries; cosine is read a quarter turn further on.
//  - A write to an angle rebuilds the nine Q1.14 terms in a 4-stage pipe
//    (table read, first products, second products, sum/clamp). in_stall is
//    high in the write cycle and while any rebuild marker is set, so the next
//    point always sees the new matrix. Writes to other addresses are ignored.
//  - Reset (synchronous, rst_n low) clears the angles, loads the identity
//    matrix and empties the pipe.
//  - Each stage holds its beat while the one after it is full and stalled,
//    so bubbles are squeezed out and a stall of out_stall backs up to
//    in_stall only once every stage is full.
module matrix_point_rotation (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  mpr_pkg::in_beat_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output mpr_pkg::out_beat_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mpr_pkg::PADDR_W-1:0] paddr,
  input  logic [mpr_pkg::PDATA_W-1:0] pwdata,
  output logic [mpr_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import mpr_pkg::*;

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  // ---------------- configuration ----------------
  logic [ANGLE_W-1:0] ang_r   [3];
  logic [ANGLE_W-1:0] ang_nxt [3];
  logic [1:0]         reg_idx;
  logic               cfg_wr;
  logic               cfg_hit;
  logic [3:0]         rb_v_r;
  logic [3:0]         rb_v_nxt;
  logic               rb_busy;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_comb begin
    ang_nxt = ang_r;
    cfg_hit = 1'b0;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_ANGLE_X: begin ang_nxt[0] = pwdata[ANGLE_W-1:0]; cfg_hit = 1'b1; end
        REG_ANGLE_Y: begin ang_nxt[1] = pwdata[ANGLE_W-1:0]; cfg_hit = 1'b1; end
        REG_ANGLE_Z: begin ang_nxt[2] = pwdata[ANGLE_W-1:0]; cfg_hit = 1'b1; end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ANGLE_X: prdata = PDATA_W'(ang_r[0]);
      REG_ANGLE_Y: prdata = PDATA_W'(ang_r[1]);
      REG_ANGLE_Z: prdata = PDATA_W'(ang_r[2]);
      default:     prdata = '0;
    endcase
  end

  // rebuild markers: [0] trig read, [1] first products, [2] second, [3] write
  assign rb_v_nxt = {rb_v_r[2:0], cfg_hit};
  assign rb_busy  = |rb_v_r;

  // ---------------- matrix rebuild pipe ----------------
  logic signed [TRIG_W-1:0] sin_r [3];
  logic signed [TRIG_W-1:0] cos_r [3];
  logic signed [TRIG_W-1:0] sin_nxt [3];
  logic signed [TRIG_W-1:0] cos_nxt [3];
  logic [IDX_W-1:0]         sin_idx [3];
  logic [IDX_W-1:0]         cos_idx [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sin_idx[a] = IDX_W'(ang_r[a]);
      cos_idx[a] = sin_idx[a] + IDX_W'(QUARTER_TURN);
      sin_nxt[a] = SINE_TAB[sin_idx[a]];
      cos_nxt[a] = SINE_TAB[cos_idx[a]];
    end
  end

  // first-level products
  logic signed [TRIG_W-1:0] cycz_r, cysz_r, sxsy_r, cxsy_r, cxsz_r;
  logic signed [TRIG_W-1:0] cxcz_r, sxsz_r, sxcz_r, cysx_r, cxcy_r, nsy_r;
  logic signed [TRIG_W-1:0] cycz_nxt, cysz_nxt, sxsy_nxt, cxsy_nxt, cxsz_nxt;
  logic signed [TRIG_W-1:0] cxcz_nxt, sxsz_nxt, sxcz_nxt, cysx_nxt, cxcy_nxt, nsy_nxt;
  // second-level products
  logic signed [TRIG_W-1:0] sxsycz_r, sxsysz_r, cxsycz_r, cxsysz_r;
  logic signed [TRIG_W-1:0] sxsycz_nxt, sxsysz_nxt, cxsycz_nxt, cxsysz_nxt;

  assign cycz_nxt = mr(cos_r[1], cos_r[2]);
  assign cysz_nxt = mr(cos_r[1], sin_r[2]);
  assign sxsy_nxt = mr(sin_r[0], sin_r[1]);
  assign cxsy_nxt = mr(cos_r[0], sin_r[1]);
  assign cxsz_nxt = mr(cos_r[0], sin_r[2]);
  assign cxcz_nxt = mr(cos_r[0], cos_r[2]);
  assign sxsz_nxt = mr(sin_r[0], sin_r[2]);
  assign sxcz_nxt = mr(sin_r[0], cos_r[2]);
  assign cysx_nxt = mr(cos_r[1], sin_r[0]);
  assign cxcy_nxt = mr(cos_r[0], cos_r[1]);
  assign nsy_nxt  = -sin_r[1];

  assign sxsycz_nxt = mr(sxsy_r, cos_r[2]);
  assign sxsysz_nxt = mr(sxsy_r, sin_r[2]);
  assign cxsycz_nxt = mr(cxsy_r, cos_r[2]);
  assign cxsysz_nxt = mr(cxsy_r, sin_r[2]);

  logic signed [TRIG_W-1:0] mat_r   [9];
  logic signed [TRIG_W-1:0] mat_nxt [9];

  always_comb begin
    mat_nxt = mat_r;
    if (rb_v_r[3]) begin
      mat_nxt[0] = clamp_term((TRIG_W+1)'(cycz_r));
      mat_nxt[1] = clamp_term((TRIG_W+1)'(cysz_r));
      mat_nxt[2] = clamp_term((TRIG_W+1)'(nsy_r));
      mat_nxt[3] = clamp_term((TRIG_W+1)'(sxsycz_r) - (TRIG_W+1)'(cxsz_r));
      mat_nxt[4] = clamp_term((TRIG_W+1)'(sxsysz_r) + (TRIG_W+1)'(cxcz_r));
      mat_nxt[5] = clamp_term((TRIG_W+1)'(cysx_r));
      mat_nxt[6] = clamp_term((TRIG_W+1)'(cxsycz_r) + (TRIG_W+1)'(sxsz_r));
      mat_nxt[7] = clamp_term((TRIG_W+1)'(cxsysz_r) - (TRIG_W+1)'(sxcz_r));
      mat_nxt[8] = clamp_term((TRIG_W+1)'(cxcy_r));
    end
  end

  // ---------------- point pipe ----------------
  logic v1_r, v2_r, v3_r;
  logic v1_nxt, v2_nxt, v3_nxt;
  logic rdy1, rdy2, rdy3;
  logic in_acc;

  assign rdy3     = !v3_r || !out_stall;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1 || rb_busy || cfg_wr;
  assign in_acc   = in_valid && !in_stall;

  assign v1_nxt = rdy1 ? in_acc : v1_r;
  assign v2_nxt = rdy2 ? v1_r   : v2_r;
  assign v3_nxt = rdy3 ? v2_r   : v3_r;

  // stage 1: nine products, index = coord*3 + column
  logic signed [COORD_W-1:0] crd [3];
  logic signed [PROD_W-1:0]  pr_r   [9];
  logic signed [PROD_W-1:0]  pr_nxt [9];
  logic                      last1_r, last2_r;

  assign crd[0] = in_data.in_x;
  assign crd[1] = in_data.in_y;
  assign crd[2] = in_data.in_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int c = 0; c < 3; c++) begin
        pr_nxt[3*i + c] = PROD_W'(crd[i]) * PROD_W'(mat_r[3*i + c]);
      end
    end
  end

  // stage 2: three-term sums, rounded half up
  logic signed [SUM_W-1:0] acc    [3];
  logic signed [RS_W-1:0]  rs_r   [3];
  logic signed [RS_W-1:0]  rs_nxt [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c]    = SUM_W'(pr_r[c]) + SUM_W'(pr_r[3 + c]) + SUM_W'(pr_r[6 + c]) + SUM_HALF;
      rs_nxt[c] = acc[c][SUM_W-1:TRIG_FRAC_BITS];
    end
  end

  // stage 3: saturate to 24 bits
  logic signed [COORD_W-1:0] sat [3];
  out_beat_t                 out_nxt;
  out_beat_t                 out_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if ((&rs_r[c][RS_W-1:COORD_W-1]) || !(|rs_r[c][RS_W-1:COORD_W-1])) begin
        sat[c] = rs_r[c][COORD_W-1:0];
      end else if (rs_r[c][RS_W-1]) begin
        sat[c] = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
        sat[c] = {1'b0, {(COORD_W-1){1'b1}}};
      end
    end
    out_nxt.out_x    = sat[0];
    out_nxt.out_y    = sat[1];
    out_nxt.out_z    = sat[2];
    out_nxt.out_last = last2_r;
  end

  assign out_valid = v3_r;
  assign out_data  = out_r;

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) ang_r[a] <= '0;
      for (int k = 0; k < 9; k++) begin
        mat_r[k] <= (k == 0 || k == 4 || k == 8) ? TRIG_ONE : '0;
      end
      rb_v_r <= '0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
    end else begin
      ang_r  <= ang_nxt;
      mat_r  <= mat_nxt;
      rb_v_r <= rb_v_nxt;
      v1_r   <= v1_nxt;
      v2_r   <= v2_nxt;
      v3_r   <= v3_nxt;
    end
  end

  // rebuild payload follows the angles every cycle; only rb_v_r[3] commits it
  always_ff @(posedge clk) begin
    sin_r    <= sin_nxt;
    cos_r    <= cos_nxt;
    cycz_r   <= cycz_nxt;
    cysz_r   <= cysz_nxt;
    sxsy_r   <= sxsy_nxt;
    cxsy_r   <= cxsy_nxt;
    cxsz_r   <= cxsz_nxt;
    cxcz_r   <= cxcz_nxt;
    sxsz_r   <= sxsz_nxt;
    sxcz_r   <= sxcz_nxt;
    cysx_r   <= cysx_nxt;
    cxcy_r   <= cxcy_nxt;
    nsy_r    <= nsy_nxt;
    sxsycz_r <= sxsycz_nxt;
    sxsysz_r <= sxsysz_nxt;
    cxsycz_r <= cxsycz_nxt;
    cxsysz_r <= cxsysz_nxt;
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      pr_r    <= pr_nxt;
      last1_r <= in_data.last_point;
    end
    if (rdy2) begin
      rs_r    <= rs_nxt;
      last2_r <= last1_r;
    end
    if (rdy3) begin
      out_r   <= out_nxt;
    end
  end

endmodule

FILE: test/tb_matrix_point_rotation.sv
// Testbench for matrix_point_rotation: APB angle writes, point beats in,
// rotated beats checked against a fixed-point predictor kept here.
// Depends on mpr_pkg and the matrix_point_rotation RTL.
`timescale 1ns / 100ps

module tb_matrix_point_rotation;
  import mpr_pkg::*;

  // index 3 has no register behind it; writes there must be dropped
  localparam logic [1:0] REG_UNMAPPED = 2'd3;
  localparam longint TERM_ONE  = longint'(1) << TRIG_FRAC_BITS;
  localparam longint TERM_HALF = longint'(1) << (TRIG_FRAC_BITS - 1);
  localparam longint COORD_MAX = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -(longint'(1) << (COORD_W - 1));
  localparam real    PI_REAL   = 3.14159265358979323846;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  in_beat_t           in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_beat_t          out_data;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [PDATA_W-1:0] pwdata    = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  matrix_point_rotation dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor state: own sine table, shadow angles, the live matrix and a
  // scratch copy of unclamped terms (used when hunting for overshoot).
  // ---------------------------------------------------------------------
  longint           sine_q14 [ANGLE_STEPS];
  longint           mat_term [9];
  longint           raw_term [9];
  logic [ANGLE_W-1:0] angle_x = '0;
  logic [ANGLE_W-1:0] angle_y = '0;
  logic [ANGLE_W-1:0] angle_z = '0;

  out_beat_t expected_points [$];
  out_beat_t due_point;

  int idle_pct        = 0;
  int stall_pct       = 0;
  int mismatch_count  = 0;
  int points_rotated  = 0;
  int settings_used   = 0;

  // sin(2*pi*i/N) in Q1.14, halves rounded away from zero
  task automatic fill_sine_table();
    real v;
    for (int i = 0; i < ANGLE_STEPS; i++) begin
      v = $sin(2.0 * PI_REAL * i / ANGLE_STEPS) * (2.0 ** TRIG_FRAC_BITS);
      if (v >= 0.0) sine_q14[i] = longint'($rtoi(v + 0.5));
      else          sine_q14[i] = -longint'($rtoi(0.5 - v));
    end
  endtask

  function automatic longint trig_at(input int idx);
    return sine_q14[idx % ANGLE_STEPS];
  endfunction

  // Q1.14 product, round half up (>>> floors)
  function automatic longint qmul(input longint a, input longint b);
    return (a * b + TERM_HALF) >>> TRIG_FRAC_BITS;
  endfunction

  // nine terms, row*3+col, before clamping
  task automatic compose_terms(input int ax, input int ay, input int az);
    longint sx, cx, sy, cy, sz, cz;
    sx = trig_at(ax); cx = trig_at(ax + ANGLE_STEPS / 4);
    sy = trig_at(ay); cy = trig_at(ay + ANGLE_STEPS / 4);
    sz = trig_at(az); cz = trig_at(az + ANGLE_STEPS / 4);
    raw_term[0] = qmul(cy, cz);
    raw_term[1] = qmul(cy, sz);
    raw_term[2] = -sy;
    raw_term[3] = qmul(qmul(sx, sy), cz) - qmul(cx, sz);
    raw_term[4] = qmul(qmul(sx, sy), sz) + qmul(cx, cz);
    raw_term[5] = qmul(cy, sx);
    raw_term[6] = qmul(qmul(cx, sy), cz) + qmul(sx, sz);
    raw_term[7] = qmul(qmul(cx, sy), sz) - qmul(sx, cz);
    raw_term[8] = qmul(cx, cy);
  endtask

  task automatic load_matrix();
    compose_terms(angle_x, angle_y, angle_z);
    for (int k = 0; k < 9; k++) begin
      if (raw_term[k] > TERM_ONE)       mat_term[k] = TERM_ONE;
      else if (raw_term[k] < -TERM_ONE) mat_term[k] = -TERM_ONE;
      else                              mat_term[k] = raw_term[k];
    end
  endtask

  // one output coordinate: column c of the matrix, rounded, saturated
  function automatic logic [COORD_W-1:0] rotated_coord(input longint x, input longint y,
                                                       input longint z, input int c);
    longint acc;
    acc = x * mat_term[c] + y * mat_term[3 + c] + z * mat_term[6 + c];
    acc = (acc + TERM_HALF) >>> TRIG_FRAC_BITS;
    if (acc > COORD_MAX)      acc = COORD_MAX;
    else if (acc < COORD_MIN) acc = COORD_MIN;
    return acc[COORD_W-1:0];
  endfunction

  function automatic out_beat_t predict_beat(input in_beat_t p);
    out_beat_t o;
    longint    x, y, z;
    x = p.in_x;
    y = p.in_y;
    z = p.in_z;
    o.out_x    = rotated_coord(x, y, z, 0);
    o.out_y    = rotated_coord(x, y, z, 1);
    o.out_z    = rotated_coord(x, y, z, 2);
    o.out_last = p.last_point;
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic in_beat_t make_point(input longint x, input longint y,
                                          input longint z, input bit last);
    in_beat_t p;
    p.in_x       = x[COORD_W-1:0];
    p.in_y       = y[COORD_W-1:0];
    p.in_z       = z[COORD_W-1:0];
    p.last_point = last;
    return p;
  endfunction

  // mostly full-range noise, with rails and small values mixed in
  function automatic longint random_coord();
    case ($urandom_range(9))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2, 3:    return longint'($urandom_range(2048)) - 1024;
      default: return longint'($signed(24'($urandom())));
    endcase
  endfunction

  function automatic int random_angle();
    case ($urandom_range(7))
      0:       return 0;
      1:       return (1 << ANGLE_W) - 1;
      2:       return (ANGLE_STEPS / 4) * $urandom_range(3);
      default: return $urandom_range((1 << ANGLE_W) - 1);
    endcase
  endfunction

  // Drive one beat, hold it until taken, then maybe idle for a while.
  // in_valid stays high when no gap follows so back-to-back beats stream.
  task automatic send_point(input in_beat_t p);
    int gap;
    in_data  <= p;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_points.push_back(predict_beat(p));
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait for every expected beat, then let the 3-stage pipe settle before
  // anything touches the angle registers.
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // APB write: setup then access; takes effect at the access edge.
  // The bus is left idle before the next transfer.
  task automatic reg_write(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_ANGLE_X: angle_x = val[ANGLE_W-1:0];
      REG_ANGLE_Y: angle_y = val[ANGLE_W-1:0];
      REG_ANGLE_Z: angle_z = val[ANGLE_W-1:0];
      default: ;
    endcase
    if (idx != REG_UNMAPPED) load_matrix();
    @(posedge clk);
  endtask

  task automatic reg_check(input logic [1:0] idx);
    logic [PDATA_W-1:0] want;
    case (idx)
      REG_ANGLE_X: want = PDATA_W'(angle_x);
      REG_ANGLE_Y: want = PDATA_W'(angle_y);
      default:     want = PDATA_W'(angle_z);
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      $error("prdata: expected %0h, got %0h", want, prdata);
      mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // all three angles; now and then junk rides in the unused upper bits
  task automatic set_angles(input int ax, input int ay, input int az);
    logic [PDATA_W-1:0] junk;
    junk = ($urandom_range(3) == 0) ? ($urandom() & ~PDATA_W'(8'hFF)) : '0;
    reg_write(REG_ANGLE_X, junk | PDATA_W'(ax));
    reg_write(REG_ANGLE_Y, junk | PDATA_W'(ay));
    reg_write(REG_ANGLE_Z, junk | PDATA_W'(az));
    settings_used++;
  endtask

  // ---------------------------------------------------------------------
  // Result side: random stall, and each taken beat checked against the
  // oldest prediction, field by field.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        $error("out beat: none expected, got x=%0d y=%0d z=%0d last=%0b",
               out_data.out_x, out_data.out_y, out_data.out_z, out_data.out_last);
        mismatch_count++;
      end else begin
        due_point = expected_points.pop_front();
        points_rotated++;
        if (out_data.out_x !== due_point.out_x) begin
          $error("out_x: expected %0d, got %0d", due_point.out_x, out_data.out_x);
          mismatch_count++;
        end
        if (out_data.out_y !== due_point.out_y) begin
          $error("out_y: expected %0d, got %0d", due_point.out_y, out_data.out_y);
          mismatch_count++;
        end
        if (out_data.out_z !== due_point.out_z) begin
          $error("out_z: expected %0d, got %0d", due_point.out_z, out_data.out_z);
          mismatch_count++;
        end
        if (out_data.out_last !== due_point.out_last) begin
          $error("out_last: expected %0b, got %0b", due_point.out_last, out_data.out_last);
          mismatch_count++;
        end
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Out of reset the matrix is identity: points pass through untouched,
  // rails included, and the registers read back zero.
  task automatic test_identity_after_reset();
    send_point(make_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
    send_point(make_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0));
    send_point(make_point(0, 0, 0, 1'b1));
    send_point(make_point(-1, 1, -256, 1'b0));
    drain_pipe();
    reg_check(REG_ANGLE_X);
    reg_check(REG_ANGLE_Y);
    reg_check(REG_ANGLE_Z);
  endtask

  // quarter turns about each axis, then one combined half, three-quarter and quarter turn
  task automatic test_quarter_turns();
    set_angles(ANGLE_STEPS / 4, 0, 0);
    send_point(make_point(100000, -200000, 300000, 1'b0));
    send_point(make_point(COORD_MAX, 0, COORD_MIN, 1'b1));
    drain_pipe();
    set_angles(0, ANGLE_STEPS / 4, 0);
    send_point(make_point(100000, -200000, 300000, 1'b1));
    send_point(make_point(COORD_MAX, 0, COORD_MIN, 1'b0));
    drain_pipe();
    set_angles(0, 0, ANGLE_STEPS / 4);
    send_point(make_point(100000, -200000, 300000, 1'b0));
    send_point(make_point(COORD_MAX, 0, COORD_MIN, 1'b1));
    drain_pipe();
    set_angles(ANGLE_STEPS / 2, 3 * ANGLE_STEPS / 4, ANGLE_STEPS / 4);
    send_point(make_point(100000, -200000, 300000, 1'b1));
    send_point(make_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0));
    drain_pipe();
  endtask

  // Upper data bits are dropped, the unmapped slot changes nothing, and
  // every angle reads back as written. Top angle value checked too.
  task automatic test_register_port();
    reg_write(REG_ANGLE_X, 32'hFFFF_FF40);
    reg_write(REG_ANGLE_Y, 32'h0000_0155);
    reg_write(REG_ANGLE_Z, 32'h8000_00FF);
    reg_write(REG_UNMAPPED, 32'h0000_0077);
    settings_used++;
    reg_check(REG_ANGLE_X);
    reg_check(REG_ANGLE_Y);
    reg_check(REG_ANGLE_Z);
    send_point(make_point(-3000000, 4000000, 123456, 1'b1));
    send_point(make_point(COORD_MIN, COORD_MAX, 0, 1'b0));
    drain_pipe();
  endtask

  // 45 degrees about z sums x and -y at ~0.707 each: rail inputs overflow
  task automatic test_saturation();
    set_angles(0, 0, ANGLE_STEPS / 8);
    send_point(make_point(COORD_MAX, COORD_MIN, 0, 1'b1));
    send_point(make_point(COORD_MIN, COORD_MAX, 0, 1'b0));
    send_point(make_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
    drain_pipe();
  endtask

  // Find angles whose rounded terms step past +/-1 so the clamp matters.
  // With y at a quarter turn and x, z tied, two terms become sin^2+cos^2.
  task automatic test_term_clamp();
    int ax, ay, az;
    bit hit;
    ax  = ANGLE_STEPS / 8;
    ay  = ANGLE_STEPS / 4;
    az  = ANGLE_STEPS / 8;
    hit = 1'b0;
    for (int yq = 1; yq < 4 && !hit; yq += 2) begin
      for (int a = 0; a < ANGLE_STEPS && !hit; a++) begin
        for (int d = 0; d < ANGLE_STEPS && !hit; d += ANGLE_STEPS / 2) begin
          compose_terms(a, yq * ANGLE_STEPS / 4, (a + d) % ANGLE_STEPS);
          for (int k = 0; k < 9; k++) begin
            if (!hit && (raw_term[k] > TERM_ONE || raw_term[k] < -TERM_ONE)) begin
              hit = 1'b1;
              ax  = a;
              ay  = yq * ANGLE_STEPS / 4;
              az  = (a + d) % ANGLE_STEPS;
            end
          end
        end
      end
    end
    set_angles(ax, ay, az);
    send_point(make_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0));
    send_point(make_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1));
    drain_pipe();
  endtask

  // Four idle/stall mixes, several angle sets in each, ~900 beats in all.
  task automatic test_random_traffic();
    int n;
    for (int mix = 0; mix < 4; mix++) begin
      case (mix)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 80; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 80; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      for (int s = 0; s < 6; s++) begin
        set_angles(random_angle(), random_angle(), random_angle());
        n = 30 + $urandom_range(15);
        repeat (n) begin
          send_point(make_point(random_coord(), random_coord(), random_coord(),
                                bit'($urandom_range(1))));
        end
        drain_pipe();
      end
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    fill_sine_table();
    load_matrix();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_identity_after_reset();
    test_quarter_turns();
    test_register_port();
    test_saturation();
    test_term_clamp();
    test_random_traffic();
    drain_pipe();

    $display("%0d rotated beats checked over %0d angle settings,", points_rotated,
             settings_used);
    $display("with free-running, sender-idle, receiver-stall and mixed traffic");
    if (mismatch_count == 0) begin
      $display("tb_matrix_point_rotation: clean");
    end else begin
      $display("tb_matrix_point_rotation: errors");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("tb_matrix_point_rotation: errors");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/mpr_pkg.sv
hdl/matrix_point_rotation.sv
test/tb_matrix_point_rotation.sv
